### rtl/assert_macros.svh
// Assertion macros used by grnr_fifo (clock clk_i, reset rst_ni).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold while out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/grnr_pkg.sv
// Shared types, constants and widths of the grid rotate resampler.
package grnr_pkg;

  // Fixed fractional formats and map limits
  localparam int MAX_SIDE         = 256;
  localparam int ANGLE_FRAC_BITS  = 14;
  localparam int OFFSET_FRAC_BITS = 8;

  // Field widths
  localparam int DIM_W    = 9;
  localparam int ANGLE_W  = 16;
  localparam int OFFSET_W = 18;
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 8;
  localparam int COORD_W  = 9;

  // Cell store
  localparam int STORE_DEPTH = 65536;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam logic [VALUE_W-1:0] OUTSIDE_VALUE = '1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Stream and register port widths
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 8;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  // Datapath widths
  localparam int DIM_MAX  = (1 << DIM_W) - 1;
  localparam int SIDE_CAP = (MAX_SIDE < DIM_MAX) ? MAX_SIDE : DIM_MAX;
  localparam int SIDE_W   = $clog2(SIDE_CAP + 1);
  localparam int IDX_W    = $clog2(SIDE_CAP);
  localparam int FRAC_W   = ANGLE_FRAC_BITS + OFFSET_FRAC_BITS;
  localparam int DX_W     = COORD_W + 1;
  localparam int AX_W     = ((DX_W + OFFSET_FRAC_BITS > OFFSET_W) ?
                             DX_W + OFFSET_FRAC_BITS : OFFSET_W) + 1;
  localparam int PROD_W   = AX_W + ANGLE_W;
  localparam int SUM_W    = ((PROD_W > SIDE_W + FRAC_W) ? PROD_W : SIDE_W + FRAC_W) + 2;
  localparam int RND_W    = SUM_W + 1 - FRAC_W;
  localparam int LIN_W    = (IDX_W + SIDE_W + 1 > STORE_AW) ? IDX_W + SIDE_W + 1 : STORE_AW;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH  = 3'd0,
    REG_MAP_HEIGHT = 3'd1,
    REG_OUT_DIM    = 3'd2,
    REG_COS_ANGLE  = 3'd3,
    REG_SIN_ANGLE  = 3'd4,
    REG_OFFSET_X   = 3'd5,
    REG_OFFSET_Y   = 3'd6
  } reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]           map_width;
    logic [DIM_W-1:0]           map_height;
    logic [DIM_W-1:0]           out_dim;
    logic signed [ANGLE_W-1:0]  cos_angle;
    logic signed [ANGLE_W-1:0]  sin_angle;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;
  } cfg_t;

  // One classified request as it sits in the queue
  typedef struct packed {
    func_e                  func;
    logic [INDEX_W-1:0]     load_index;
    logic [VALUE_W-1:0]     load_value;
    logic signed [AX_W-1:0] ax;
    logic signed [AX_W-1:0] ay;
  } item_t;

endpackage

### rtl/grid_rotate_nearest_resample_top.sv
// Top level of the nearest-neighbor grid rotate resampler with its register file.
//
// Load requests (tuser 0) write one 8-bit cell into a 65536-entry store at
// load_index; fetch requests (tuser 1) return the cell at (out_row, out_col)
// of the rotated square output grid, or all ones with in_bounds low when the
// source lies off the map; loads return nothing. The block takes one request
// per cycle while the queue has room and returns at most one result per cycle
// while m_axis_tready is high: a four-entry queue feeds a five-stage back end
// (products, rotated sums, rounding, bounds and address, store read), and the
// back end advances whenever its result register is empty or taken. The store
// has one write and one read port used at the same stage, so loads and
// fetches keep their order. The store is not cleared at reset: load a cell
// before fetching it. The user must write registers only while no request is
// in flight; the block itself does not enforce this.
module grid_rotate_nearest_resample_top #(
  parameter int QUEUE_DEPTH = grnr_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] load_index, [23:16] load_value, [32:24] out_row, [41:33] out_col
  input  logic [grnr_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] func
  input  logic                          s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] cell_value
  output logic [grnr_pkg::M_DATA_W-1:0] m_axis_tdata,
  // [0] in_bounds
  output logic                          m_axis_tuser,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grnr_pkg::APB_AW-1:0]   paddr,
  input  logic [grnr_pkg::APB_DW-1:0]   pwdata,
  output logic [grnr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import grnr_pkg::*;

  cfg_t  cfg_q;
  reg_e  reg_sel;
  logic  cfg_we;
  item_t item, head;
  logic  push, pop, full, empty;

  // Register file
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width  <= DIM_W'(256);
      cfg_q.map_height <= DIM_W'(256);
      cfg_q.out_dim    <= DIM_W'(362);
      cfg_q.cos_angle  <= ANGLE_W'(16384);
      cfg_q.sin_angle  <= '0;
      cfg_q.offset_x   <= '0;
      cfg_q.offset_y   <= '0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_MAP_WIDTH:  cfg_q.map_width  <= pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT: cfg_q.map_height <= pwdata[DIM_W-1:0];
        REG_OUT_DIM:    cfg_q.out_dim    <= pwdata[DIM_W-1:0];
        REG_COS_ANGLE:  cfg_q.cos_angle  <= pwdata[ANGLE_W-1:0];
        REG_SIN_ANGLE:  cfg_q.sin_angle  <= pwdata[ANGLE_W-1:0];
        REG_OFFSET_X:   cfg_q.offset_x   <= pwdata[OFFSET_W-1:0];
        REG_OFFSET_Y:   cfg_q.offset_y   <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback, signed fields sign-extended
  always_comb begin
    unique case (reg_sel)
      REG_MAP_WIDTH:  prdata = APB_DW'(cfg_q.map_width);
      REG_MAP_HEIGHT: prdata = APB_DW'(cfg_q.map_height);
      REG_OUT_DIM:    prdata = APB_DW'(cfg_q.out_dim);
      REG_COS_ANGLE:  prdata = APB_DW'(cfg_q.cos_angle);
      REG_SIN_ANGLE:  prdata = APB_DW'(cfg_q.sin_angle);
      REG_OFFSET_X:   prdata = APB_DW'(cfg_q.offset_x);
      REG_OFFSET_Y:   prdata = APB_DW'(cfg_q.offset_y);
      default:        prdata = '0;
    endcase
  end

  grnr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg_q),
    .full_i        (full),
    .push_o        (push),
    .item_o        (item)
  );

  grnr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  grnr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### rtl/grnr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module grnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/grnr_fifo.sv
// Short request queue between the front and back parts.
`include "assert_macros.svh"

module grnr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  grnr_pkg::item_t item_i,
  input  logic           pop_i,
  output grnr_pkg::item_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import grnr_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o && !pop_i, "queue overflow")
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "queue underflow")
  `ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == CNT_W'($past(count_q) + 1'b1),
               "queue count did not advance on push")
  `ASSERT_IMPL(a_empty_ptrs, count_q == '0, rd_ptr_q == wr_ptr_q,
               "empty queue with unequal pointers")

endmodule

### rtl/grnr_front.sv
// Front part: takes stream requests, classifies them and centers fetch coordinates.
module grnr_front (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [grnr_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  grnr_pkg::cfg_t                  cfg_i,
  input  logic                            full_i,
  output logic                            push_o,
  output grnr_pkg::item_t                 item_o
);
  import grnr_pkg::*;

  logic [INDEX_W-1:0]         load_index;
  logic [VALUE_W-1:0]         load_value;
  logic [COORD_W-1:0]         out_row;
  logic [COORD_W-1:0]         out_col;
  logic [DIM_W-2:0]           half_dim;
  logic signed [DX_W-1:0]     dx, dy;
  logic signed [OFFSET_W-1:0] off_x, off_y;

  // Unpack tdata: load_index, load_value, out_row, out_col
  assign load_index = s_axis_tdata[INDEX_W-1:0];
  assign load_value = s_axis_tdata[INDEX_W +: VALUE_W];
  assign out_row    = s_axis_tdata[INDEX_W + VALUE_W +: COORD_W];
  assign out_col    = s_axis_tdata[INDEX_W + VALUE_W + COORD_W +: COORD_W];

  // Requests go into the queue whenever it has room
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // Center on the output grid and remove the translation
  assign half_dim = cfg_i.out_dim[DIM_W-1:1];
  assign off_x    = cfg_i.offset_x;
  assign off_y    = cfg_i.offset_y;
  assign dx       = $signed(DX_W'(out_row) - DX_W'(half_dim));
  assign dy       = $signed(DX_W'(out_col) - DX_W'(half_dim));

  always_comb begin
    item_o.func       = s_axis_tuser ? FUNC_FETCH : FUNC_LOAD;
    item_o.load_index = load_index;
    item_o.load_value = load_value;
    item_o.ax         = (AX_W'(dx) <<< OFFSET_FRAC_BITS) - AX_W'(off_x);
    item_o.ay         = (AX_W'(dy) <<< OFFSET_FRAC_BITS) - AX_W'(off_y);
  end

endmodule

### rtl/grnr_back.sv
// Back part: rotation pipeline, bounds check, cell store access and result register.
module grnr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  grnr_pkg::cfg_t                cfg_i,
  input  grnr_pkg::item_t               head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [grnr_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser
);
  import grnr_pkg::*;

  localparam logic [SUM_W:0] RND_HALF = (SUM_W + 1)'(1) << (FRAC_W - 1);

  logic adv;

  // Clamped map size
  logic [SIDE_W-1:0] w_side, h_side;
  logic [SUM_W-1:0]  half_h, half_w;

  // Stage 1: products
  logic signed [AX_W-1:0]    ax, ay;
  logic signed [ANGLE_W-1:0] cos_a, sin_a;
  logic                      v1_q;
  func_e                     f1_q;
  logic [INDEX_W-1:0]        idx1_q;
  logic [VALUE_W-1:0]        val1_q;
  logic signed [PROD_W-1:0]  pxc_q, pys_q, pyc_q, pxs_q;

  // Stage 2: rotated sums
  logic                      v2_q;
  func_e                     f2_q;
  logic [INDEX_W-1:0]        idx2_q;
  logic [VALUE_W-1:0]        val2_q;
  logic [SUM_W-1:0]          rx_q, ry_q;

  // Stage 3: rounded source coordinates
  logic [SUM_W:0]            rx_b, ry_b;
  logic                      v3_q;
  func_e                     f3_q;
  logic [INDEX_W-1:0]        idx3_q;
  logic [VALUE_W-1:0]        val3_q;
  logic [RND_W-1:0]          mi_q, ni_q;

  // Stage 4: bounds and store address
  logic                      in_map;
  logic [LIN_W-1:0]          lin;
  logic                      v4_q;
  func_e                     f4_q;
  logic [VALUE_W-1:0]        val4_q;
  logic [STORE_AW-1:0]       addr4_q;
  logic                      ib4_q;

  // Stage 5: result register
  logic                      ov_q;
  logic                      ib5_q;
  logic [VALUE_W-1:0]        rdata;
  logic                      ram_we, ram_re;

  // Whole pipeline moves when the result register is free or being taken
  assign adv   = !ov_q || m_axis_tready;
  assign pop_o = adv && !empty_i;

  assign w_side = (32'(cfg_i.map_width) > SIDE_CAP) ? SIDE_W'(SIDE_CAP) :
                                                      SIDE_W'(cfg_i.map_width);
  assign h_side = (32'(cfg_i.map_height) > SIDE_CAP) ? SIDE_W'(SIDE_CAP) :
                                                       SIDE_W'(cfg_i.map_height);
  assign half_h = SUM_W'(h_side >> 1) << FRAC_W;
  assign half_w = SUM_W'(w_side >> 1) << FRAC_W;

  assign ax    = head_i.ax;
  assign ay    = head_i.ay;
  assign cos_a = cfg_i.cos_angle;
  assign sin_a = cfg_i.sin_angle;

  // Round half away from zero: add half, minus one for negative values, then shift
  assign rx_b = {rx_q[SUM_W-1], rx_q} + RND_HALF - (SUM_W + 1)'(rx_q[SUM_W-1]);
  assign ry_b = {ry_q[SUM_W-1], ry_q} + RND_HALF - (SUM_W + 1)'(ry_q[SUM_W-1]);

  // Inside test and row-major address
  assign in_map = !mi_q[RND_W-1] && (mi_q < RND_W'(h_side)) &&
                  !ni_q[RND_W-1] && (ni_q < RND_W'(w_side));
  assign lin    = LIN_W'(mi_q[IDX_W-1:0]) * LIN_W'(w_side) + LIN_W'(ni_q[IDX_W-1:0]);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q && (f4_q == FUNC_FETCH);
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q    <= head_i.func;
      idx1_q  <= head_i.load_index;
      val1_q  <= head_i.load_value;
      pxc_q   <= ax * cos_a;
      pys_q   <= ay * sin_a;
      pyc_q   <= ay * cos_a;
      pxs_q   <= ax * sin_a;

      f2_q    <= f1_q;
      idx2_q  <= idx1_q;
      val2_q  <= val1_q;
      rx_q    <= {{(SUM_W - PROD_W){pxc_q[PROD_W-1]}}, pxc_q} +
                 {{(SUM_W - PROD_W){pys_q[PROD_W-1]}}, pys_q} + half_h;
      ry_q    <= {{(SUM_W - PROD_W){pyc_q[PROD_W-1]}}, pyc_q} -
                 {{(SUM_W - PROD_W){pxs_q[PROD_W-1]}}, pxs_q} + half_w;

      f3_q    <= f2_q;
      idx3_q  <= idx2_q;
      val3_q  <= val2_q;
      mi_q    <= rx_b[SUM_W:FRAC_W];
      ni_q    <= ry_b[SUM_W:FRAC_W];

      f4_q    <= f3_q;
      val4_q  <= val3_q;
      addr4_q <= (f3_q == FUNC_LOAD) ? idx3_q : lin[STORE_AW-1:0];
      ib4_q   <= in_map;

      ib5_q   <= ib4_q;
    end
  end

  // Cell store: loads write, fetches read, both at stage 4 in request order
  assign ram_we = adv && v4_q && (f4_q == FUNC_LOAD);
  assign ram_re = adv && v4_q && (f4_q == FUNC_FETCH);

  grnr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr4_q),
    .wdata_i (val4_q),
    .re_i    (ram_re),
    .raddr_i (addr4_q),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = ib5_q ? rdata : OUTSIDE_VALUE;
  assign m_axis_tuser  = ib5_q;

endmodule
